@@ design/xor_checked_frame_receiver_unit_macros.svh @@
// Assertion macros for the XOR-checked frame receiver.
// Included by the RTL files that carry concurrent checks; no other dependencies.
`ifndef XOR_CHECKED_FRAME_RECEIVER_UNIT_MACROS_SVH
`define XOR_CHECKED_FRAME_RECEIVER_UNIT_MACROS_SVH

`ifndef SYNTHESIS
// same-cycle implication
`define XCFR_ASSERT_NOW(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("xcfr check failed");
// next-cycle implication
`define XCFR_ASSERT_NEXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("xcfr check failed");
`else
`define XCFR_ASSERT_NOW(label, clk, rstn, ante, cons)
`define XCFR_ASSERT_NEXT(label, clk, rstn, ante, cons)
`endif

`endif

@@ design/xcfr_pkg.sv @@
// Shared types and constants for the XOR-checked frame receiver.
// No dependencies.
package xcfr_pkg;

    // header: four preamble bytes, length, source, destination
    localparam int unsigned PreambleBytes = 4;
    localparam int unsigned HdrBytes      = 7;
    localparam int unsigned PosWidth      = 9;

    localparam logic [31:0] PREAMBLE_RESET = 32'h0102_0304;

    typedef enum logic {
        KIND_PAYLOAD = 1'b0,
        KIND_END     = 1'b1
    } item_kind_t;

    typedef enum logic [1:0] {
        STATUS_OK           = 2'd0,
        STATUS_BAD_PREAMBLE = 2'd1,
        STATUS_BAD_CHECK    = 2'd2
    } frame_status_t;

    typedef struct packed {
        item_kind_t    kind;
        logic [7:0]    data_byte;
        logic [7:0]    source_addr;
        logic [7:0]    dest_addr;
        logic [7:0]    payload_count;
        frame_status_t frame_status;
        logic          last;
    } result_t;

endpackage

@@ design/xcfr_in_stage.sv @@
// Input register for the frame receiver: holds one received byte.
// Depends on nothing but the clock and reset.
module xcfr_in_stage (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_valid,
    output logic       s_ready,
    input  logic [7:0] s_rx_byte,
    input  logic       pop,
    output logic       byte_valid,
    output logic [7:0] byte_data
);

    logic       valid_reg;
    logic       valid_next;
    logic [7:0] byte_reg;

    // accept when empty or when the held byte is consumed this cycle
    assign s_ready = !valid_reg || pop;

    always_comb begin
        valid_next = valid_reg;
        if (s_valid && s_ready) begin
            valid_next = 1'b1;
        end else if (pop) begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    // payload, no reset
    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            byte_reg <= s_rx_byte;
        end
    end

    assign byte_valid = valid_reg;
    assign byte_data  = byte_reg;

endmodule

@@ design/xcfr_frame_core.sv @@
// Frame tracking: position, header capture, running XOR and status.
// Uses xcfr_pkg and the assertion macros header.
`include "xor_checked_frame_receiver_unit_macros.svh"

module xcfr_frame_core (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            cfg_wr_en,
    input  logic [31:0]     cfg_wr_data,
    input  logic            byte_valid,
    input  logic [7:0]      byte_data,
    input  logic            res_ready,
    output logic            pop,
    output logic            res_valid,
    output xcfr_pkg::result_t res
);
    import xcfr_pkg::*;

    logic [31:0]         preamble_reg;
    logic [PosWidth-1:0] pos_reg;
    logic [PosWidth-1:0] pos_next;
    logic [7:0]          len_reg;
    logic [7:0]          len_next;
    logic [7:0]          src_reg;
    logic [7:0]          src_next;
    logic [7:0]          dst_reg;
    logic [7:0]          dst_next;
    logic [7:0]          xor_reg;
    logic [7:0]          xor_next;
    logic                pre_good_reg;
    logic                pre_good_next;

    logic [7:0]          want_byte;
    logic [PosWidth-1:0] payload_end;
    logic                in_preamble;
    logic                in_header;
    logic                is_payload;
    logic                is_end;

    // a byte is consumed whenever the result side can take its outcome
    assign pop = byte_valid && res_ready;

    // expected preamble byte, first byte in the top lane
    always_comb begin
        case (pos_reg[1:0])
            2'd0:    want_byte = preamble_reg[31:24];
            2'd1:    want_byte = preamble_reg[23:16];
            2'd2:    want_byte = preamble_reg[15:8];
            2'd3:    want_byte = preamble_reg[7:0];
            default: want_byte = preamble_reg[7:0];
        endcase
    end

    assign payload_end = PosWidth'(HdrBytes) + {1'b0, len_reg};
    assign in_preamble = pos_reg < PosWidth'(PreambleBytes);
    assign in_header   = pos_reg < PosWidth'(HdrBytes);
    assign is_payload  = !in_header && (pos_reg < payload_end);
    assign is_end      = !in_header && !is_payload;

    // next frame state
    always_comb begin
        pos_next      = pos_reg;
        len_next      = len_reg;
        src_next      = src_reg;
        dst_next      = dst_reg;
        xor_next      = xor_reg;
        pre_good_next = pre_good_reg;
        if (pop) begin
            if (is_end) begin
                pos_next      = '0;
                xor_next      = '0;
                pre_good_next = 1'b1;
            end else begin
                pos_next = pos_reg + 1'b1;
                xor_next = xor_reg ^ byte_data;
                if (in_preamble && (byte_data != want_byte)) begin
                    pre_good_next = 1'b0;
                end
                if (pos_reg == PosWidth'(PreambleBytes)) begin
                    len_next = byte_data;
                end
                if (pos_reg == PosWidth'(PreambleBytes + 1)) begin
                    src_next = byte_data;
                end
                if (pos_reg == PosWidth'(PreambleBytes + 2)) begin
                    dst_next = byte_data;
                end
            end
        end
    end

    // result for the byte consumed this cycle
    always_comb begin
        res_valid         = pop && !in_header;
        res.source_addr   = src_reg;
        res.dest_addr     = dst_reg;
        res.payload_count = len_reg;
        if (is_end) begin
            res.kind      = KIND_END;
            res.data_byte = '0;
            res.last      = 1'b1;
            if (!pre_good_reg) begin
                res.frame_status = STATUS_BAD_PREAMBLE;
            end else if (xor_reg != byte_data) begin
                res.frame_status = STATUS_BAD_CHECK;
            end else begin
                res.frame_status = STATUS_OK;
            end
        end else begin
            res.kind         = KIND_PAYLOAD;
            res.data_byte    = byte_data;
            res.last         = 1'b0;
            res.frame_status = STATUS_OK;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            preamble_reg <= PREAMBLE_RESET;
            pos_reg      <= '0;
            len_reg      <= '0;
            src_reg      <= '0;
            dst_reg      <= '0;
            xor_reg      <= '0;
            pre_good_reg <= 1'b1;
        end else begin
            if (cfg_wr_en) begin
                preamble_reg <= cfg_wr_data;
            end
            pos_reg      <= pos_next;
            len_reg      <= len_next;
            src_reg      <= src_next;
            dst_reg      <= dst_next;
            xor_reg      <= xor_next;
            pre_good_reg <= pre_good_next;
        end
    end

    // position never runs past the check byte of a full-length frame
    `XCFR_ASSERT_NOW(a_pos_range, aclk, aresetn, 1'b1, pos_reg <= PosWidth'(HdrBytes + 255))
    // the check byte returns the frame state to its start values
    `XCFR_ASSERT_NEXT(a_end_clears, aclk, aresetn, pop && is_end, (pos_reg == '0) && (xor_reg == '0) && pre_good_reg)
    // the preamble flag only drops on a preamble byte
    `XCFR_ASSERT_NOW(a_flag_in_preamble, aclk, aresetn, $fell(pre_good_reg), $past(pos_reg) < PosWidth'(PreambleBytes))

endmodule

@@ design/xcfr_out_stage.sv @@
// Output register for the frame receiver results.
// Uses xcfr_pkg for the result structure.
module xcfr_out_stage (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              res_valid,
    input  xcfr_pkg::result_t res,
    output logic              res_ready,
    output logic              m_valid,
    input  logic              m_ready,
    output xcfr_pkg::result_t m_res
);
    import xcfr_pkg::*;

    logic    valid_reg;
    logic    valid_next;
    result_t res_reg;

    // free slot, or the held result leaves this cycle
    assign res_ready = !valid_reg || m_ready;

    always_comb begin
        valid_next = valid_reg;
        if (res_ready) begin
            valid_next = res_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (res_ready && res_valid) begin
            res_reg <= res;
        end
    end

    assign m_valid = valid_reg;
    assign m_res   = res_reg;

endmodule

@@ design/xor_checked_frame_receiver_unit.sv @@
// Top level of the XOR-checked frame receiver.
// Uses xcfr_pkg, xcfr_in_stage, xcfr_frame_core and xcfr_out_stage.
//
//  channel   direction  handshake           payload
//  s_        in         s_valid / s_ready   s_rx_byte
//  m_        out        m_valid / m_ready   m_kind .. m_last
//  cfg_      in         cfg_wr_en           cfg_wr_data (preamble)
//
// One byte per cycle while m_ready stays high; a result reaches m_ through the
// input register, then the result register. Header bytes give no result.
// Reset is synchronous on aresetn and clears all frame state.
// When m_ready is low the result register holds, the input register fills
// and s_ready then drops until a result transfer frees space.
module xor_checked_frame_receiver_unit (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_wr_en,
    input  logic [31:0] cfg_wr_data,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [7:0]  s_rx_byte,
    output logic        m_valid,
    input  logic        m_ready,
    output logic        m_kind,
    output logic [7:0]  m_data_byte,
    output logic [7:0]  m_source_addr,
    output logic [7:0]  m_dest_addr,
    output logic [7:0]  m_payload_count,
    output logic [1:0]  m_frame_status,
    output logic        m_last
);
    import xcfr_pkg::*;

    logic       byte_valid;
    logic [7:0] byte_data;
    logic       pop;
    logic       res_valid;
    logic       res_ready;
    result_t    res;
    result_t    m_res;

    xcfr_in_stage u_in (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_valid    (s_valid),
        .s_ready    (s_ready),
        .s_rx_byte  (s_rx_byte),
        .pop        (pop),
        .byte_valid (byte_valid),
        .byte_data  (byte_data)
    );

    xcfr_frame_core u_core (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .byte_valid  (byte_valid),
        .byte_data   (byte_data),
        .res_ready   (res_ready),
        .pop         (pop),
        .res_valid   (res_valid),
        .res         (res)
    );

    xcfr_out_stage u_out (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .res_valid (res_valid),
        .res       (res),
        .res_ready (res_ready),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_res     (m_res)
    );

    assign m_kind          = m_res.kind;
    assign m_data_byte     = m_res.data_byte;
    assign m_source_addr   = m_res.source_addr;
    assign m_dest_addr     = m_res.dest_addr;
    assign m_payload_count = m_res.payload_count;
    assign m_frame_status  = m_res.frame_status;
    assign m_last          = m_res.last;

endmodule
